@@ rtl/core/mlfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_pkg
// Shared constants and types for the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
package mlfs_pkg;
    localparam int TASKS  = 64;
    localparam int LEVELS = 5;
    localparam int TW     = $clog2(TASKS);
    localparam int LW     = 3;
    localparam int CW     = $clog2(TASKS + 1);
    localparam int AW     = $clog2(LEVELS * TASKS);

    localparam logic [2:0] OP_ADMIT  = 3'd0;
    localparam logic [2:0] OP_WAKE   = 3'd1;
    localparam logic [2:0] OP_PICK   = 3'd2;
    localparam logic [2:0] OP_RETURN = 3'd3;
    localparam logic [2:0] OP_REMOVE = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_QUEUED  = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_NOTASK  = 2'd3;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [TW-1:0] wdata;
        logic [AW-1:0] raddr;
    } fifo_cmd_t;

    // per-task word: queued flag, level and ready tick
    typedef struct packed {
        logic          queued;
        logic [LW-1:0] level;
        logic [31:0]   since;
    } task_word_t;

    function automatic logic [AW-1:0] fifo_addr(input logic [LW-1:0] lv,
                                                input logic [CW-1:0] pos);
        logic [AW-1:0] a;
        a = AW'(lv) * AW'(TASKS) + AW'(pos);
        return a;
    endfunction
endpackage

@@ rtl/core/mlfs_fifo_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_fifo_ram
// Queue entry memory: one write, one registered read per cycle.
// ----------------------------------------------------------------------------
module mlfs_fifo_ram
    import mlfs_pkg::*;
(
    input  logic          clk,
    input  fifo_cmd_t     cmd,
    output logic [TW-1:0] rdata
);
    logic [TW-1:0] mem [LEVELS*TASKS];

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
        rdata <= mem[cmd.raddr];
    end
endmodule

@@ rtl/core/mlfs_since_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_since_ram
// Per-task state memory (queued flag, level, ready tick) with registered read.
// ----------------------------------------------------------------------------
module mlfs_since_ram
    import mlfs_pkg::*;
(
    input  logic          clk,
    input  logic          we,
    input  logic [TW-1:0] waddr,
    input  task_word_t    wdata,
    input  logic [TW-1:0] raddr,
    output task_word_t    rdata
);
    task_word_t mem [TASKS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/multilevel_feedback_scheduler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_top
// Five-level feedback task scheduler built around a queue entry memory.
// ----------------------------------------------------------------------------
// channel   | handshake            | payload
// request   | in_valid / in_ready  | operation task_req now still_runnable over_slice
// result    | out_valid / out_ready| status chosen_valid chosen_task chosen_level wait_time
// config    | cfg_we               | cfg_data (age_limit)
//
// One request at a time. Admit/wake check the task word and enqueue at the tail.
// Remove/return search the level queue up to the task, then shift each entry
// behind it forward. Pick ages levels 1..4, reading every queued task; a
// promotion shifts the entries behind it. It then probes up to 5 levels for a
// non-empty queue, reads the head and shifts the rest forward.
// Reset starts a clearing pass of the task memory; in_ready stays low.
// A finished result waits in the output register; the next request may start.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_top
    import mlfs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [19:0]   cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    operation,
    input  logic [5:0]    task_req,
    input  logic [31:0]   now,
    input  logic          still_runnable,
    input  logic          over_slice,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    status,
    output logic          chosen_valid,
    output logic [5:0]    chosen_task,
    output logic [2:0]    chosen_level,
    output logic [31:0]   wait_time
);
    // states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;  // decide operation, read task word
    localparam logic [3:0] S_TCHK   = 4'd2;  // check task word
    localparam logic [3:0] S_FRD    = 4'd3;  // find: issue read at pos
    localparam logic [3:0] S_FCMP   = 4'd4;  // find: compare read data
    localparam logic [3:0] S_SRD    = 4'd5;  // shift: read pos+1
    localparam logic [3:0] S_SWR    = 4'd6;  // shift: write pos
    localparam logic [3:0] S_ARD    = 4'd7;  // age: read entry
    localparam logic [3:0] S_ATS    = 4'd8;  // age: read task word
    localparam logic [3:0] S_ACMP   = 4'd9;  // age: compare
    localparam logic [3:0] S_PICK   = 4'd10; // pick head
    localparam logic [3:0] S_PTS    = 4'd11;
    localparam logic [3:0] S_PDONE  = 4'd12;
    localparam logic [3:0] S_AFTER  = 4'd13; // after removal
    localparam logic [3:0] S_OUT    = 4'd14;
    localparam logic [3:0] S_CLR    = 4'd15; // clearing pass after reset

    // after-shift continuation
    localparam logic [1:0] K_REM  = 2'd0;
    localparam logic [1:0] K_RET  = 2'd1;
    localparam logic [1:0] K_AGE  = 2'd2;
    localparam logic [1:0] K_PICK = 2'd3;

    logic [3:0]  st_reg;
    logic [19:0] age_reg;
    logic [2:0]  op_reg;
    logic [TW-1:0] t_reg;
    logic [31:0] now_reg;
    logic        run_reg, over_reg;
    logic [CW-1:0] cnt_reg [LEVELS];
    logic [LW-1:0] lv_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] u_pos_reg;
    logic [TW-1:0] u_reg;
    logic [1:0]  kont_reg;
    task_word_t  tw_reg;
    logic [TW-1:0] clr_reg;
    logic [1:0]  stat_reg;
    logic        cv_reg;
    logic [TW-1:0] ct_reg;
    logic [LW-1:0] cl_reg;
    logic [31:0] wt_reg;
    logic        ov_reg;
    logic [1:0]  ostat_reg;
    logic        ocv_reg;
    logic [TW-1:0] oct_reg;
    logic [LW-1:0] ocl_reg;
    logic [31:0] owt_reg;

    fifo_cmd_t   fcmd;
    logic [TW-1:0] frd;
    logic        tw_e;
    logic [TW-1:0] tw_a, tr_a;
    task_word_t  tw_d, trd;

    mlfs_fifo_ram u_fifo (.clk(clk), .cmd(fcmd), .rdata(frd));
    mlfs_since_ram u_since (.clk(clk), .we(tw_e), .waddr(tw_a), .wdata(tw_d),
                            .raddr(tr_a), .rdata(trd));

    assign in_ready     = (st_reg == S_IDLE);
    assign out_valid    = ov_reg;
    assign status       = ostat_reg;
    assign chosen_valid = ocv_reg;
    assign chosen_task  = oct_reg;
    assign chosen_level = ocl_reg;
    assign wait_time    = owt_reg;

    logic [LW-1:0] lv_src;
    logic [LW-1:0] up_lv;
    logic [31:0]   elapsed;
    logic          enq_go;
    logic [LW-1:0] enq_lv;
    logic          enq_room;
    logic          out_load;

    // level a returning task that overran moves to, saturating at the lowest
    assign lv_src  = (st_reg == S_AFTER) ? tw_reg.level : trd.level;
    assign up_lv   = (lv_src < LW'(LEVELS - 1)) ? lv_src + 1'b1 : lv_src;
    assign elapsed = now_reg - trd.since;
    assign out_load = (st_reg == S_OUT) && (!ov_reg || out_ready);

    // tail enqueue request for this cycle
    always_comb
    begin
        enq_go = 1'b0;
        enq_lv = trd.level;
        case (st_reg)
            S_TCHK:
            begin
                if (!trd.queued && (op_reg == OP_ADMIT || op_reg == OP_WAKE ||
                                    (op_reg == OP_RETURN && run_reg)))
                begin
                    enq_go = 1'b1;
                    if (op_reg == OP_ADMIT)
                        enq_lv = '0;
                    else if (op_reg == OP_RETURN && over_reg)
                        enq_lv = up_lv;
                    else
                        enq_lv = trd.level;
                end
            end
            S_AFTER:
            begin
                if (kont_reg == K_RET && run_reg)
                begin
                    enq_go = 1'b1;
                    enq_lv = up_lv;
                end
                else if (kont_reg == K_AGE)
                begin
                    enq_go = 1'b1;
                    enq_lv = lv_reg - 1'b1;
                end
            end
            default: ;
        endcase
        enq_room = (cnt_reg[enq_lv] < CW'(TASKS));
    end

    // combinational memory commands
    always_comb
    begin
        fcmd.we    = 1'b0;
        fcmd.waddr = fifo_addr(lv_reg, pos_reg);
        fcmd.wdata = frd;
        fcmd.raddr = fifo_addr(lv_reg, pos_reg);
        tw_e = 1'b0;
        tw_a = t_reg;
        tw_d = '0;
        tr_a = t_reg;
        if (enq_go)
        begin
            fcmd.we    = enq_room;
            fcmd.waddr = fifo_addr(enq_lv, cnt_reg[enq_lv]);
            fcmd.wdata = (kont_reg == K_AGE && st_reg == S_AFTER) ? u_reg : t_reg;
        end
        case (st_reg)
            S_CLR:
            begin
                tw_e = 1'b1;
                tw_a = clr_reg;
            end
            S_TCHK:
            begin
                if (enq_go)
                begin
                    tw_e = 1'b1;
                    tw_d.queued = enq_room;
                    tw_d.level  = enq_lv;
                    tw_d.since  = now_reg;
                end
            end
            S_SRD:   fcmd.raddr = fifo_addr(lv_reg, pos_reg + 1'b1);
            S_SWR:   fcmd.we = 1'b1;
            S_AFTER:
            begin
                case (kont_reg)
                    K_RET:
                    begin
                        tw_e = 1'b1;
                        if (run_reg)
                        begin
                            tw_d.queued = enq_room;
                            tw_d.level  = enq_lv;
                            tw_d.since  = now_reg;
                        end
                        else
                        begin
                            tw_d.queued = 1'b0;
                            tw_d.level  = tw_reg.level;
                            tw_d.since  = tw_reg.since;
                        end
                    end
                    K_REM:
                    begin
                        tw_e = 1'b1;
                        tw_d.queued = 1'b0;
                        tw_d.level  = tw_reg.level;
                        tw_d.since  = tw_reg.since;
                    end
                    K_AGE:
                    begin
                        // promotion keeps the old ready tick
                        tw_e = 1'b1;
                        tw_a = u_reg;
                        tw_d.queued = enq_room;
                        tw_d.level  = enq_room ? enq_lv : tw_reg.level;
                        tw_d.since  = tw_reg.since;
                    end
                    default: ;
                endcase
            end
            S_ATS:   tr_a = frd;
            S_PICK:  fcmd.raddr = fifo_addr(lv_reg, '0);
            S_PTS:   tr_a = frd;
            S_PDONE:
            begin
                tw_e = 1'b1;
                tw_a = u_reg;
                tw_d.queued = 1'b0;
                tw_d.level  = trd.level;
                tw_d.since  = trd.since;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_CLR;
            clr_reg   <= '0;
            age_reg   <= 20'd30;
            op_reg    <= '0;
            t_reg     <= '0;
            now_reg   <= '0;
            run_reg   <= 1'b0;
            over_reg  <= 1'b0;
            lv_reg    <= '0;
            pos_reg   <= '0;
            u_pos_reg <= '0;
            u_reg     <= '0;
            kont_reg  <= K_REM;
            tw_reg    <= '0;
            stat_reg  <= ST_OK;
            cv_reg    <= 1'b0;
            ct_reg    <= '0;
            cl_reg    <= '0;
            wt_reg    <= '0;
            ov_reg    <= 1'b0;
            ostat_reg <= ST_OK;
            ocv_reg   <= 1'b0;
            oct_reg   <= '0;
            ocl_reg   <= '0;
            owt_reg   <= '0;
            for (int i = 0; i < LEVELS; i++) cnt_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we) age_reg <= cfg_data;

            // output register: load a finished result, drop it when taken
            if (out_load)
            begin
                ov_reg    <= 1'b1;
                ostat_reg <= stat_reg;
                ocv_reg   <= cv_reg;
                oct_reg   <= ct_reg;
                ocl_reg   <= cl_reg;
                owt_reg   <= wt_reg;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end

            case (st_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == TW'(TASKS - 1)) st_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg <= operation; t_reg <= task_req; now_reg <= now;
                        run_reg <= still_runnable; over_reg <= over_slice;
                        stat_reg <= ST_OK; cv_reg <= 1'b0; ct_reg <= '0;
                        cl_reg <= '0; wt_reg <= '0;
                        st_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    case (op_reg)
                        OP_ADMIT, OP_WAKE, OP_RETURN, OP_REMOVE: st_reg <= S_TCHK;
                        OP_PICK:
                        begin
                            kont_reg <= K_AGE; lv_reg <= LW'(1); pos_reg <= '0;
                            st_reg <= S_ARD;
                        end
                        default: st_reg <= S_OUT;
                    endcase
                end
                S_TCHK:
                begin
                    tw_reg <= trd;
                    if (enq_go)
                    begin
                        if (enq_room) cnt_reg[enq_lv] <= cnt_reg[enq_lv] + 1'b1;
                        st_reg <= S_OUT;
                    end
                    else if (trd.queued)
                    begin
                        if (op_reg == OP_ADMIT || op_reg == OP_WAKE ||
                            (op_reg == OP_RETURN && run_reg && !over_reg))
                        begin
                            stat_reg <= ST_QUEUED; st_reg <= S_OUT;
                        end
                        else
                        begin
                            kont_reg <= (op_reg == OP_REMOVE) ? K_REM : K_RET;
                            lv_reg <= trd.level; pos_reg <= '0;
                            st_reg <= S_FRD;
                        end
                    end
                    else
                    begin
                        if (op_reg == OP_REMOVE) stat_reg <= ST_NOTASK;
                        st_reg <= S_OUT;
                    end
                end
                S_FRD:
                begin
                    if (pos_reg < cnt_reg[lv_reg]) st_reg <= S_FCMP;
                    else
                    begin
                        if (op_reg == OP_REMOVE) stat_reg <= ST_NOTASK;
                        st_reg <= S_AFTER;
                    end
                end
                S_FCMP:
                begin
                    if (frd == t_reg) st_reg <= S_SRD;
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1; st_reg <= S_FRD;
                    end
                end
                S_SRD:
                begin
                    if (CW'(pos_reg + 1'b1) < cnt_reg[lv_reg]) st_reg <= S_SWR;
                    else
                    begin
                        cnt_reg[lv_reg] <= cnt_reg[lv_reg] - 1'b1;
                        st_reg <= S_AFTER;
                    end
                end
                S_SWR:
                begin
                    pos_reg <= pos_reg + 1'b1; st_reg <= S_SRD;
                end
                S_AFTER:
                begin
                    case (kont_reg)
                        K_RET:
                        begin
                            if (enq_go && enq_room)
                                cnt_reg[enq_lv] <= cnt_reg[enq_lv] + 1'b1;
                            st_reg <= S_OUT;
                        end
                        K_AGE:
                        begin
                            if (enq_room) cnt_reg[enq_lv] <= cnt_reg[enq_lv] + 1'b1;
                            // next entry has shifted into the same position
                            pos_reg <= u_pos_reg;
                            st_reg <= S_ARD;
                        end
                        default: st_reg <= S_OUT;
                    endcase
                end
                S_ARD:
                begin
                    if (pos_reg < cnt_reg[lv_reg]) st_reg <= S_ATS;
                    else if (lv_reg == LW'(LEVELS - 1))
                    begin
                        lv_reg <= '0; st_reg <= S_PICK;
                    end
                    else
                    begin
                        lv_reg <= lv_reg + 1'b1; pos_reg <= '0;
                    end
                end
                S_ATS:
                begin
                    u_reg <= frd; st_reg <= S_ACMP;
                end
                S_ACMP:
                begin
                    if (elapsed > {12'd0, age_reg})
                    begin
                        tw_reg <= trd; u_pos_reg <= pos_reg;
                        kont_reg <= K_AGE; st_reg <= S_SRD;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1; st_reg <= S_ARD;
                    end
                end
                S_PICK:
                begin
                    pos_reg <= '0;
                    if (cnt_reg[lv_reg] != '0) st_reg <= S_PTS;
                    else if (lv_reg == LW'(LEVELS - 1))
                    begin
                        stat_reg <= ST_EMPTY; st_reg <= S_OUT;
                    end
                    else lv_reg <= lv_reg + 1'b1;
                end
                S_PTS:
                begin
                    u_reg <= frd; st_reg <= S_PDONE;
                end
                S_PDONE:
                begin
                    cv_reg <= 1'b1; ct_reg <= u_reg; cl_reg <= lv_reg;
                    wt_reg <= elapsed;
                    kont_reg <= K_PICK; st_reg <= S_SRD;
                end
                S_OUT:
                begin
                    if (out_load) st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !in_ready)
        else $error("request taken while busy");
    a_cv_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && chosen_valid) |-> (status == ST_OK))
        else $error("picked task with bad status");
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (chosen_level < LW'(LEVELS)))
        else $error("level out of range");
endmodule

@@ test/multilevel_feedback_scheduler_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_top_test
// Self-checking bench for the five-level feedback scheduler. A directed table
// covers empty picks, refused enqueues, aging, level saturation and unknown
// operations; random request streams with a running tick follow, across
// several age limits. Each result is compared against the table's expected
// values for typed rows, else against a queue-level model.
module multilevel_feedback_scheduler_top_test
    import mlfs_pkg::*;
;

    // one result as the block reports it
    typedef struct packed {
        logic [1:0]  status;
        logic        cvalid;
        logic [5:0]  ctask;
        logic [2:0]  clevel;
        logic [31:0] wait_t;
    } sched_result_t;

    // one row of the directed table
    typedef struct {
        logic [2:0]    op;
        logic [5:0]    tsk;
        logic [31:0]   tick;
        logic          run;
        logic          over;
        bit            typed;
        sched_result_t res;
    } dir_row_t;

    localparam int CYCLE_LIMIT = 30000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [19:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  operation = '0;
    logic [5:0]  task_req = '0;
    logic [31:0] now = '0;
    logic        still_runnable = 1'b0;
    logic        over_slice = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic        chosen_valid;
    logic [5:0]  chosen_task;
    logic [2:0]  chosen_level;
    logic [31:0] wait_time;

    always #5 clk = ~clk;

    multilevel_feedback_scheduler_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .task_req(task_req), .now(now),
        .still_runnable(still_runnable), .over_slice(over_slice),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .chosen_valid(chosen_valid), .chosen_task(chosen_task),
        .chosen_level(chosen_level), .wait_time(wait_time)
    );

    // ---------------- scheduler model state ----------------
    logic [5:0]  run_queue [LEVELS][$];
    logic [2:0]  slot_level [TASKS];
    logic [31:0] slot_ready [TASKS];
    bit          slot_queued [TASKS];
    logic [19:0] age_limit_m = 20'd30;

    sched_result_t pending_results [$];
    dir_row_t      dir_rows [$];
    int  errors = 0;
    bit  calm = 1'b0;       // phase with no idling on either side
    logic [31:0] tick;

    // pull a task out of its queue; false when it was not queued
    function automatic bit dequeue_slot(input logic [5:0] t);
        bit found;
        found = 1'b0;
        if (!slot_queued[t])
            return 1'b0;
        for (int k = 0; k < run_queue[slot_level[t]].size(); k++)
        begin
            if (!found && run_queue[slot_level[t]][k] == t)
            begin
                run_queue[slot_level[t]].delete(k);
                found = 1'b1;
            end
        end
        slot_queued[t] = 1'b0;
        return found;
    endfunction

    function automatic void enqueue_slot(input logic [2:0] lv, input logic [5:0] t,
                                         input logic [31:0] tk);
        run_queue[lv].push_back(t);
        slot_level[t]  = lv;
        slot_queued[t] = 1'b1;
        slot_ready[t]  = tk;
    endfunction

    // apply one request to the model and return the result it produces
    function automatic sched_result_t schedule_step(input logic [2:0] op,
                                                    input logic [5:0] t,
                                                    input logic [31:0] tk,
                                                    input logic run, input logic over);
        sched_result_t r;
        int j;
        logic [5:0] u;
        logic [31:0] waited;
        bit picked;
        r = '0;
        picked = 1'b0;
        case (op)
            OP_PICK:
            begin
                // aging: levels scanned upward, promotion keeps the old ready tick
                for (int i = 1; i < LEVELS; i++)
                begin
                    j = 0;
                    while (j < run_queue[i].size())
                    begin
                        u = run_queue[i][j];
                        waited = tk - slot_ready[u];
                        if (waited > {12'd0, age_limit_m})
                        begin
                            run_queue[i].delete(j);
                            run_queue[i-1].push_back(u);
                            slot_level[u] = 3'(i - 1);
                        end
                        else
                            j++;
                    end
                end
                r.status = ST_EMPTY;
                for (int lv = 0; lv < LEVELS; lv++)
                begin
                    if (!picked && run_queue[lv].size() > 0)
                    begin
                        u = run_queue[lv].pop_front();
                        slot_queued[u] = 1'b0;
                        picked   = 1'b1;
                        r.status = ST_OK;
                        r.cvalid = 1'b1;
                        r.ctask  = u;
                        r.clevel = 3'(lv);
                        r.wait_t = tk - slot_ready[u];
                    end
                end
            end
            OP_ADMIT, OP_WAKE:
            begin
                if (slot_queued[t])
                    r.status = ST_QUEUED;
                else
                    enqueue_slot((op == OP_ADMIT) ? 3'd0 : slot_level[t], t, tk);
            end
            OP_RETURN:
            begin
                if (run)
                begin
                    if (over)
                    begin
                        void'(dequeue_slot(t));
                        if (slot_level[t] < LEVELS - 1)
                            slot_level[t]++;
                    end
                    if (slot_queued[t])
                        r.status = ST_QUEUED;
                    else
                        enqueue_slot(slot_level[t], t, tk);
                end
                else
                    void'(dequeue_slot(t));
            end
            OP_REMOVE:
            begin
                if (!dequeue_slot(t))
                    r.status = ST_NOTASK;
            end
            default: ;   // unknown codes are ignored
        endcase
        return r;
    endfunction

    // idle gap: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 19);
        if (calm || r < 11)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // hand one request over; model runs at the accepting edge
    task automatic send_request(input logic [2:0] op, input logic [5:0] t,
                                input logic [31:0] tk, input logic run,
                                input logic over, input bit typed,
                                input sched_result_t typed_res);
        sched_result_t r;
        int gap;
        gap = idle_gap();
        repeat (gap) @(negedge clk);
        operation      = op;
        task_req       = t;
        now            = tk;
        still_runnable = run;
        over_slice     = over;
        in_valid       = 1'b1;
        do @(posedge clk); while (!in_ready);
        r = schedule_step(op, t, tk, run, over);
        pending_results.push_back(typed ? typed_res : r);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // write age_limit once the block has drained
    task automatic set_age_limit(input logic [19:0] v);
        wait (pending_results.size() == 0);
        repeat (4) @(negedge clk);
        cfg_data = v;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we   = 1'b0;
        age_limit_m = v;
    endtask

    function automatic void add_row(input logic [2:0] op, input logic [5:0] t,
                                    input logic [31:0] tk, input logic run,
                                    input logic over, input bit typed,
                                    input logic [1:0] st, input logic cv,
                                    input logic [5:0] ct, input logic [2:0] cl,
                                    input logic [31:0] w);
        dir_row_t row;
        row.op = op; row.tsk = t; row.tick = tk; row.run = run; row.over = over;
        row.typed = typed;
        row.res = '{status: st, cvalid: cv, ctask: ct, clevel: cl, wait_t: w};
        dir_rows.push_back(row);
    endfunction

    // random request with a bias toward a small pool of slots
    task automatic random_request();
        int pick;
        logic [2:0] op;
        logic [5:0] t;
        pick = $urandom_range(0, 99);
        if (pick < 22)      op = OP_ADMIT;
        else if (pick < 40) op = OP_WAKE;
        else if (pick < 66) op = OP_PICK;
        else if (pick < 86) op = OP_RETURN;
        else if (pick < 96) op = OP_REMOVE;
        else                op = 3'($urandom_range(5, 7));
        t = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(0, 9));
        tick = tick + (($urandom_range(0, 15) == 0) ? $urandom_range(20, 200)
                                                    : $urandom_range(0, 6));
        send_request(op, t, tick, 1'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    // ---------------- result checking ----------------
    always @(posedge clk)
    begin
        sched_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status=%0d task=%0d", $time,
                         status, chosen_task);
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.status)
                begin
                    errors++;
                    $display("%0t: status exp %0d got %0d", $time, e.status, status);
                end
                if (chosen_valid !== e.cvalid)
                begin
                    errors++;
                    $display("%0t: chosen_valid exp %0d got %0d", $time, e.cvalid,
                             chosen_valid);
                end
                if (chosen_task !== e.ctask)
                begin
                    errors++;
                    $display("%0t: chosen_task exp %0d got %0d", $time, e.ctask,
                             chosen_task);
                end
                if (chosen_level !== e.clevel)
                begin
                    errors++;
                    $display("%0t: chosen_level exp %0d got %0d", $time, e.clevel,
                             chosen_level);
                end
                if (wait_time !== e.wait_t)
                begin
                    errors++;
                    $display("%0t: wait_time exp %0d got %0d", $time, e.wait_t,
                             wait_time);
                end
            end
        end
    end

    // result side back-pressure
    int ready_hold = 0;
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            out_ready  <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold <= idle_gap();
        end
    end

    // watchdog
    int cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("multilevel_feedback_scheduler_top: mismatch");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial
    begin
        logic [19:0] limits [5];
        logic [31:0] starts [5];
        for (int i = 0; i < TASKS; i++)
        begin
            slot_level[i]  = '0;
            slot_queued[i] = 1'b0;
            slot_ready[i]  = '0;
        end

        // directed: empty pick, missing slot, refused enqueues, aging, saturation
        add_row(OP_PICK,   6'd0,  32'd0,   0, 0, 1, ST_EMPTY,  0, 0, 0, 0);
        add_row(OP_REMOVE, 6'd5,  32'd1,   0, 0, 1, ST_NOTASK, 0, 0, 0, 0);
        add_row(OP_ADMIT,  6'd0,  32'd10,  0, 0, 1, ST_OK,     0, 0, 0, 0);
        add_row(OP_ADMIT,  6'd0,  32'd11,  0, 0, 1, ST_QUEUED, 0, 0, 0, 0);
        add_row(OP_ADMIT,  6'd63, 32'd12,  0, 0, 1, ST_OK,     0, 0, 0, 0);
        add_row(OP_WAKE,   6'd63, 32'd12,  0, 0, 1, ST_QUEUED, 0, 0, 0, 0);
        add_row(OP_RETURN, 6'd63, 32'd13,  1, 1, 1, ST_OK,     0, 0, 0, 0);
        add_row(OP_RETURN, 6'd63, 32'd13,  1, 0, 1, ST_QUEUED, 0, 0, 0, 0);
        add_row(OP_PICK,   6'd0,  32'd14,  0, 0, 1, ST_OK,     1, 0, 0, 4);
        // slot 63 has waited past the limit at level 1 and is promoted
        add_row(OP_PICK,   6'd0,  32'd100, 0, 0, 1, ST_OK,     1, 63, 0, 87);
        add_row(OP_PICK,   6'd0,  32'd101, 0, 0, 1, ST_EMPTY,  0, 0, 0, 0);
        add_row(OP_WAKE,   6'd63, 32'd102, 0, 0, 0, ST_OK,     0, 0, 0, 0);
        add_row(OP_RETURN, 6'd63, 32'd103, 0, 1, 1, ST_OK,     0, 0, 0, 0);
        add_row(OP_REMOVE, 6'd63, 32'd104, 0, 0, 1, ST_NOTASK, 0, 0, 0, 0);
        add_row(3'd5,      6'd63, 32'd105, 1, 1, 1, ST_OK,     0, 0, 0, 0);
        add_row(3'd6,      6'd42, 32'd106, 0, 0, 1, ST_OK,     0, 0, 0, 0);
        add_row(3'd7,      6'd21, 32'hFFFF_FFFF, 1, 1, 1, ST_OK, 0, 0, 0, 0);
        // walk slot 1 down to the lowest level and past it
        add_row(OP_ADMIT,  6'd1,  32'd200, 0, 0, 0, ST_OK, 0, 0, 0, 0);
        for (int i = 0; i < 5; i++)
            add_row(OP_RETURN, 6'd1, 32'(201 + i), 1, 1, 0, ST_OK, 0, 0, 0, 0);
        add_row(OP_PICK,   6'd0,  32'd210, 0, 0, 0, ST_OK, 0, 0, 0, 0);
        add_row(OP_PICK,   6'd0,  32'hFFFF_FFFF, 0, 0, 0, ST_OK, 0, 0, 0, 0);

        limits = '{20'd0, 20'hFFFFF, 20'd30, 20'd12, 20'($urandom_range(1, 300))};
        starts = '{32'd300, 32'hFFFF_FF00, 32'($urandom), 32'd5000, 32'hFFFF_F000};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_request(dir_rows[i].op, dir_rows[i].tsk, dir_rows[i].tick,
                         dir_rows[i].run, dir_rows[i].over, dir_rows[i].typed,
                         dir_rows[i].res);

        // random phases, each under its own age limit and tick origin
        for (int p = 0; p < 5; p++)
        begin
            set_age_limit(limits[p]);
            tick = starts[p];
            calm = (p == 2);
            repeat (315) random_request();
        end
        calm = 1'b0;

        wait (pending_results.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("multilevel_feedback_scheduler_top: match");
        else
            $display("multilevel_feedback_scheduler_top: mismatch");
        $finish;
    end
endmodule
